// ===== sv/ball_plate_filter_pd_servo_defines.svh =====
// Assertion macros for the ball plate servo block.
`ifndef BALL_PLATE_FILTER_PD_SERVO_DEFINES_SVH
`define BALL_PLATE_FILTER_PD_SERVO_DEFINES_SVH
`ifndef SYNTHESIS
`define BPFPS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("bpfps assertion failed");
`define BPFPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpfps assertion failed");
`else
`define BPFPS_ASSERT_ALWAYS(lbl, expr)
`define BPFPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/bpfps_pkg.sv =====
// Shared types, widths and constants of the ball plate servo block.
package bpfps_pkg;

    localparam int ADC_BITS_DEF   = 10;
    localparam int PWM_PERIOD_DEF = 3999;

    localparam int SAMPLE_W   = 10;
    localparam int POS_W      = 18;
    localparam int ERR_W      = 20;
    localparam int PULSE_W    = 11;
    localparam int CMP_W      = 12;
    localparam int TGT_W      = 14;
    localparam int GAIN_W     = 16;
    localparam int LEVEL_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Filter coefficients, Q0.16
    localparam logic [15:0] COEF_B = 16'd10499;
    localparam logic [15:0] COEF_A = 16'd44538;

    localparam logic [POS_W-1:0]   POS_MAX   = '1;
    localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2000;

    // floor(p/5) == (p*6554)>>15 for every p below 16384
    localparam logic [12:0] DIV5_MUL   = 13'd6554;
    localparam int          DIV5_SHIFT = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_X   = 3'd0,
        REG_TARGET_Y   = 3'd1,
        REG_GAIN_P_X   = 3'd2,
        REG_GAIN_D_X   = 3'd3,
        REG_GAIN_P_Y   = 3'd4,
        REG_GAIN_D_Y   = 3'd5,
        REG_LEVEL_US_X = 3'd6,
        REG_LEVEL_US_Y = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [TGT_W-1:0]   target_x;
        logic [TGT_W-1:0]   target_y;
        logic [GAIN_W-1:0]  gain_p_x;
        logic [GAIN_W-1:0]  gain_d_x;
        logic [GAIN_W-1:0]  gain_p_y;
        logic [GAIN_W-1:0]  gain_d_y;
        logic [LEVEL_W-1:0] level_us_x;
        logic [LEVEL_W-1:0] level_us_y;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        target_x:   14'd6256,
        target_y:   14'd6296,
        gain_p_x:   16'd1434,
        gain_d_x:   16'd28672,
        gain_p_y:   16'd1638,
        gain_d_y:   16'd34816,
        level_us_x: 11'd1557,
        level_us_y: 11'd1525
    };

endpackage

// ===== sv/bpfps_regs.sv =====
// Configuration register file of the ball plate servo block.
module bpfps_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we,
    input  logic [bpfps_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [bpfps_pkg::CFG_DATA_W-1:0]   i_data,
    output bpfps_pkg::t_cfg                    o_cfg
);
    import bpfps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_we) begin
            unique case (t_reg_idx'(i_idx))
                REG_TARGET_X:   r_cfg.target_x   <= i_data[TGT_W-1:0];
                REG_TARGET_Y:   r_cfg.target_y   <= i_data[TGT_W-1:0];
                REG_GAIN_P_X:   r_cfg.gain_p_x   <= i_data[GAIN_W-1:0];
                REG_GAIN_D_X:   r_cfg.gain_d_x   <= i_data[GAIN_W-1:0];
                REG_GAIN_P_Y:   r_cfg.gain_p_y   <= i_data[GAIN_W-1:0];
                REG_GAIN_D_Y:   r_cfg.gain_d_y   <= i_data[GAIN_W-1:0];
                REG_LEVEL_US_X: r_cfg.level_us_x <= i_data[LEVEL_W-1:0];
                REG_LEVEL_US_Y: r_cfg.level_us_y <= i_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/bpfps_lowpass.sv =====
// Per-axis first-order low-pass stage with its own result register.
module bpfps_lowpass #(
    parameter int ADC_BITS = bpfps_pkg::ADC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    output logic                              o_rdy,
    input  logic                              i_axis,
    input  logic [bpfps_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                              o_vld,
    input  logic                              i_rdy,
    output logic                              o_axis,
    output logic [bpfps_pkg::POS_W-1:0]       o_pos
);
    import bpfps_pkg::*;

    localparam int                 EFF_W       = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << EFF_W) - 1);

    logic                r_vld;
    logic                r_axis;
    logic [POS_W-1:0]    r_pos;
    logic [SAMPLE_W-1:0] r_prev_s [2];
    logic [POS_W-1:0]    r_prev_f [2];

    logic                fire;
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W:0]   sum_x;
    logic [26:0]         prod_b;
    logic [33:0]         prod_a;
    logic [34:0]         acc;
    logic [18:0]         rnd;
    logic [POS_W-1:0]    n_pos;

    assign o_rdy = !r_vld || i_rdy;
    assign fire  = i_vld && o_rdy;

    always_comb begin
        x      = i_sample & SAMPLE_MASK;
        sum_x  = {1'b0, x} + {1'b0, r_prev_s[i_axis]};
        prod_b = 27'(COEF_B) * 27'(sum_x);
        prod_a = 34'(COEF_A) * 34'(r_prev_f[i_axis]);
        // exact Q.24 sum, round half up to Q.8
        acc    = (35'(prod_b) << 8) + 35'(prod_a) + 35'd32768;
        rnd    = acc[34:16];
        n_pos  = (rnd > 19'(POS_MAX)) ? POS_MAX : rnd[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_prev_s <= '{default: '0};
            r_prev_f <= '{default: '0};
        end else begin
            if (o_rdy) begin
                r_vld <= i_vld;
            end
            if (fire) begin
                r_prev_s[i_axis] <= x;
                r_prev_f[i_axis] <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_axis <= i_axis;
            r_pos  <= n_pos;
        end
    end

    assign o_vld  = r_vld;
    assign o_axis = r_axis;
    assign o_pos  = r_pos;

endmodule

// ===== sv/bpfps_pd.sv =====
// Per-axis PD drive stage with saturation and its own result register.
module bpfps_pd (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bpfps_pkg::t_cfg                   i_cfg,
    input  logic                              i_vld,
    output logic                              o_rdy,
    input  logic                              i_axis,
    input  logic [bpfps_pkg::POS_W-1:0]       i_pos,
    output logic                              o_vld,
    input  logic                              i_rdy,
    output logic                              o_axis,
    output logic [bpfps_pkg::PULSE_W-1:0]     o_pulse,
    output logic [bpfps_pkg::POS_W-1:0]       o_pos
);
    import bpfps_pkg::*;

    localparam logic signed [40:0] DRV_LO = 41'(PULSE_MIN) << 20;
    localparam logic signed [40:0] DRV_HI = (41'(PULSE_MAX) + 41'd1) << 20;

    logic                    r_vld;
    logic                    r_axis;
    logic [PULSE_W-1:0]      r_pulse;
    logic [POS_W-1:0]        r_pos;
    logic signed [ERR_W-1:0] r_prev_e [2];

    logic                    fire;
    logic [TGT_W-1:0]        tgt;
    logic [GAIN_W-1:0]       kp;
    logic [GAIN_W-1:0]       kd;
    logic [LEVEL_W-1:0]      lvl;
    logic signed [18:0]      err;
    logic signed [20:0]      der;
    logic signed [35:0]      p_term;
    logic signed [37:0]      d_term;
    logic signed [40:0]      drive;
    logic [PULSE_W-1:0]      n_pulse;

    assign o_rdy = !r_vld || i_rdy;
    assign fire  = i_vld && o_rdy;

    always_comb begin
        tgt    = i_axis ? i_cfg.target_y   : i_cfg.target_x;
        kp     = i_axis ? i_cfg.gain_p_y   : i_cfg.gain_p_x;
        kd     = i_axis ? i_cfg.gain_d_y   : i_cfg.gain_d_x;
        lvl    = i_axis ? i_cfg.level_us_y : i_cfg.level_us_x;
        // setpoint Q.4 widened to Q.8
        err    = $signed({1'b0, tgt, 4'b0000}) - $signed({1'b0, i_pos});
        der    = 21'(err) - 21'(r_prev_e[i_axis]);
        p_term = $signed({1'b0, kp}) * err;
        d_term = $signed({1'b0, kd}) * der;
        drive  = $signed({10'b0, lvl, 20'b0}) + 41'(p_term) + 41'(d_term);
        if (drive < DRV_LO) begin
            n_pulse = PULSE_MIN;
        end else if (drive >= DRV_HI) begin
            n_pulse = PULSE_MAX;
        end else begin
            n_pulse = drive[30:20];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_prev_e <= '{default: '0};
        end else begin
            if (o_rdy) begin
                r_vld <= i_vld;
            end
            if (fire) begin
                r_prev_e[i_axis] <= ERR_W'(err);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_axis  <= i_axis;
            r_pulse <= n_pulse;
            r_pos   <= i_pos;
        end
    end

    assign o_vld   = r_vld;
    assign o_axis  = r_axis;
    assign o_pulse = r_pulse;
    assign o_pos   = r_pos;

endmodule

// ===== sv/ball_plate_filter_pd_servo.sv =====
// Top level of the ball plate servo: low-pass filter and PD drive per axis.
//
// Input channel: i_valid / o_stall carry one item, an axis bit and a raw
// touch panel sample. Output channel: o_valid / i_stall carry one result
// item: axis, saturated pulse width in us, inverted PWM compare value and
// the filtered position (Q10.8). Config writes use i_cfg_valid /
// o_cfg_ready (always ready) with a register index and data.
// Pipeline: input register, filter stage, PD stage, output stage.
// o_valid rises once an accepted item moves from the input, filter and PD
// registers into the output register. Without receiver stalls one item
// per cycle is sustained: each stage updates its own per-axis state as
// the item enters its register, so same-axis items may follow back to back.
// When the receiver stalls the output register holds; stages behind it
// keep filling bubbles and o_stall rises only when all four are full.
// Synchronous active-low reset empties the pipeline, zeroes the filter
// and error history of both axes and loads the default setpoints, gains
// and levelling pulses.
`include "ball_plate_filter_pd_servo_defines.svh"
module ball_plate_filter_pd_servo #(
    parameter int ADC_BITS   = bpfps_pkg::ADC_BITS_DEF,
    parameter int PWM_PERIOD = bpfps_pkg::PWM_PERIOD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_axis,
    input  logic [bpfps_pkg::SAMPLE_W-1:0]    i_sample,
    // result items
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_out_axis,
    output logic [bpfps_pkg::PULSE_W-1:0]     o_pulse_us,
    output logic [bpfps_pkg::CMP_W-1:0]       o_compare_value,
    output logic [bpfps_pkg::POS_W-1:0]       o_position,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bpfps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpfps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bpfps_pkg::*;

    localparam int PER_W = 17;

    t_cfg cfg;

    // input register stage
    logic                r_in_vld;
    logic                r_in_axis;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                in_rdy;

    // filter stage
    logic                lp_vld;
    logic                lp_rdy;
    logic                lp_axis;
    logic [POS_W-1:0]    lp_pos;

    // PD stage
    logic                pd_vld;
    logic                pd_rdy;
    logic                pd_axis;
    logic [PULSE_W-1:0]  pd_pulse;
    logic [POS_W-1:0]    pd_pos;

    // output stage
    logic                r_out_vld;
    logic                r_out_axis;
    logic [PULSE_W-1:0]  r_out_pulse;
    logic [CMP_W-1:0]    r_out_cmp;
    logic [POS_W-1:0]    r_out_pos;
    logic                out_rdy;
    logic [23:0]         div_prod;
    logic [8:0]          quot;
    logic [PER_W-1:0]    cmp_full;

    assign o_cfg_ready = 1'b1;

    bpfps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // ready ripples back from the output register
    assign out_rdy = !r_out_vld || !i_stall;
    assign in_rdy  = !r_in_vld || lp_rdy;
    assign o_stall = !in_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_rdy) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy && i_valid) begin
            r_in_axis   <= i_axis;
            r_in_sample <= i_sample;
        end
    end

    bpfps_lowpass #(
        .ADC_BITS (ADC_BITS)
    ) u_lowpass (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_in_vld),
        .o_rdy    (lp_rdy),
        .i_axis   (r_in_axis),
        .i_sample (r_in_sample),
        .o_vld    (lp_vld),
        .i_rdy    (pd_rdy),
        .o_axis   (lp_axis),
        .o_pos    (lp_pos)
    );

    bpfps_pd u_pd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_vld   (lp_vld),
        .o_rdy   (pd_rdy),
        .i_axis  (lp_axis),
        .i_pos   (lp_pos),
        .o_vld   (pd_vld),
        .i_rdy   (out_rdy),
        .o_axis  (pd_axis),
        .o_pulse (pd_pulse),
        .o_pos   (pd_pos)
    );

    // compare = period - pulse/5, divide by reciprocal multiply
    always_comb begin
        div_prod = 24'(pd_pulse) * 24'(DIV5_MUL);
        quot     = div_prod[DIV5_SHIFT +: 9];
        cmp_full = PER_W'(PWM_PERIOD) - PER_W'(quot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_rdy) begin
            r_out_vld <= pd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && pd_vld) begin
            r_out_axis  <= pd_axis;
            r_out_pulse <= pd_pulse;
            r_out_cmp   <= cmp_full[CMP_W-1:0];
            r_out_pos   <= pd_pos;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_out_axis      = r_out_axis;
    assign o_pulse_us      = r_out_pulse;
    assign o_compare_value = r_out_cmp;
    assign o_position      = r_out_pos;

    // a result on the port is always inside the servo range
    `BPFPS_ASSERT_ALWAYS(a_pulse_range,
        !o_valid || (o_pulse_us >= PULSE_MIN && o_pulse_us <= PULSE_MAX))
    // an accepted item lands in the input register
    `BPFPS_ASSERT_NEXT(a_accept_lands, i_valid && !o_stall, r_in_vld)
    // input is refused only when every stage holds an item
    `BPFPS_ASSERT_ALWAYS(a_stall_full,
        !o_stall || (r_in_vld && lp_vld && pd_vld && r_out_vld && i_stall))
    // a taken result with nothing behind it leaves the port empty
    `BPFPS_ASSERT_NEXT(a_drain, r_out_vld && !i_stall && !pd_vld, !o_valid)

endmodule

// ===== dv/tb_ball_plate_filter_pd_servo.sv =====
// Testbench for the ball plate servo: per-axis low-pass filter and PD drive checked item by item.
`timescale 1ns / 1ps

module tb_ball_plate_filter_pd_servo;

    import bpfps_pkg::*;

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
    localparam int SETTLE       = 8;       // pipeline is 4 deep, give it slack
    localparam int PHASE_ITEMS  = 290;     // random items per config phase

    // Filter coefficients, Q0.16, and the servo rails
    localparam longint unsigned LP_B     = 10499;
    localparam longint unsigned LP_A     = 44538;
    localparam longint unsigned POS_TOP  = 262143;
    localparam int              RAIL_LO  = 1000;
    localparam int              RAIL_HI  = 2000;
    localparam int              PERIOD   = 3999;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_axis;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_out_axis;
    logic [PULSE_W-1:0]    o_pulse_us;
    logic [CMP_W-1:0]      o_compare_value;
    logic [POS_W-1:0]      o_position;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ball_plate_filter_pd_servo dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_axis          (i_axis),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_axis      (o_out_axis),
        .o_pulse_us      (o_pulse_us),
        .o_compare_value (o_compare_value),
        .o_position      (o_position),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 12 ns period, inputs move on the falling edge
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Servo predictor: own copy of config and per-axis history
    // ------------------------------------------------------------------
    typedef struct packed {
        logic               axis;
        logic [PULSE_W-1:0] pulse_us;
        logic [CMP_W-1:0]   compare_value;
        logic [POS_W-1:0]   position;
    } t_drive;

    t_drive            drive_q[$];     // expected drives, oldest first
    t_cfg              cfg_m;          // mirrored register file
    logic [SAMPLE_W-1:0] hist_sample [2];
    logic [POS_W-1:0]  hist_pos [2];
    longint            hist_err [2];

    int  err_count   = 0;
    int  items_sent  = 0;
    int  drives_seen = 0;
    int  cfg_writes  = 0;
    int  cycle_count = 0;

    // Sender / receiver idling knobs, shared with the test tasks
    bit  tx_idle     = 1'b1;
    bit  rx_idle     = 1'b1;
    int  hold_cycles = 0;              // long receiver hold-off, counted below

    function automatic void reset_model();
        cfg_m.target_x   = 14'd6256;
        cfg_m.target_y   = 14'd6296;
        cfg_m.gain_p_x   = 16'd1434;
        cfg_m.gain_d_x   = 16'd28672;
        cfg_m.gain_p_y   = 16'd1638;
        cfg_m.gain_d_y   = 16'd34816;
        cfg_m.level_us_x = 11'd1557;
        cfg_m.level_us_y = 11'd1525;
        for (int a = 0; a < 2; a++) begin
            hist_sample[a] = '0;
            hist_pos[a]    = '0;
            hist_err[a]    = 0;
        end
    endfunction

    // Register write as the block sees it: data masked to the register width
    function automatic void apply_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TARGET_X:   cfg_m.target_x   = data[TGT_W-1:0];
            REG_TARGET_Y:   cfg_m.target_y   = data[TGT_W-1:0];
            REG_GAIN_P_X:   cfg_m.gain_p_x   = data[GAIN_W-1:0];
            REG_GAIN_D_X:   cfg_m.gain_d_x   = data[GAIN_W-1:0];
            REG_GAIN_P_Y:   cfg_m.gain_p_y   = data[GAIN_W-1:0];
            REG_GAIN_D_Y:   cfg_m.gain_d_y   = data[GAIN_W-1:0];
            REG_LEVEL_US_X: cfg_m.level_us_x = data[LEVEL_W-1:0];
            REG_LEVEL_US_Y: cfg_m.level_us_y = data[LEVEL_W-1:0];
            default: ;
        endcase
    endfunction

    // One accepted sample -> the drive it must produce; advances history
    function automatic t_drive servo_predict(logic ax, logic [SAMPLE_W-1:0] x);
        longint unsigned acc;
        longint          tgt, kp, kd, lvl, err, der, drv;
        int              a, pulse, cmp;
        t_drive          r;
        a = int'(ax);
        // low-pass: exact in Q.24, round half up to Q.8, clip at the top
        acc = (LP_B * (longint'(x) + longint'(hist_sample[a]))) << 8;
        acc = acc + LP_A * longint'(hist_pos[a]);
        acc = (acc + 64'd32768) >> 16;
        if (acc > POS_TOP)
            acc = POS_TOP;
        hist_sample[a] = x;
        hist_pos[a]    = acc[POS_W-1:0];
        // PD in Q.20, setpoint widened from Q.4 to Q.8
        tgt = longint'(ax ? cfg_m.target_y   : cfg_m.target_x);
        kp  = longint'(ax ? cfg_m.gain_p_y   : cfg_m.gain_p_x);
        kd  = longint'(ax ? cfg_m.gain_d_y   : cfg_m.gain_d_x);
        lvl = longint'(ax ? cfg_m.level_us_y : cfg_m.level_us_x);
        err = (tgt << 4) - longint'(acc);
        der = err - hist_err[a];
        hist_err[a] = err;
        drv = (lvl << 20) + kp * err + kd * der;
        // floor to us, then clamp (negative drives land on the low rail)
        if (drv < (longint'(RAIL_LO) << 20))
            pulse = RAIL_LO;
        else if (drv >= (longint'(RAIL_HI + 1) << 20))
            pulse = RAIL_HI;
        else
            pulse = int'(drv >>> 20);
        cmp = PERIOD - pulse / 5;
        r.axis          = ax;
        r.pulse_us      = pulse[PULSE_W-1:0];
        r.compare_value = cmp[CMP_W-1:0];
        r.position      = acc[POS_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitors. Everything is sampled at the rising edge, before the
    // block's own registers update in that step.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_inputs
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                drive_q.push_back(servo_predict(i_axis, i_sample));
                items_sent++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg(t_reg_idx'(i_cfg_index), i_cfg_data);
                cfg_writes++;
            end
        end
    end

    // Each accepted drive is checked against the oldest pending expectation
    always @(posedge i_clk) begin : check_drive
        t_drive want;
        if (i_rst_n && o_valid && !i_stall) begin
            drives_seen++;
            if (drive_q.size() == 0) begin
                report_mismatch("drive with no sample pending", longint'(o_pulse_us), 0);
            end else begin
                want = drive_q.pop_front();
                if (o_out_axis !== want.axis)
                    report_mismatch("out_axis", longint'(o_out_axis),
                                    longint'(want.axis));
                if (o_pulse_us !== want.pulse_us)
                    report_mismatch("pulse_us", longint'(o_pulse_us),
                                    longint'(want.pulse_us));
                if (o_compare_value !== want.compare_value)
                    report_mismatch("compare_value", longint'(o_compare_value),
                                    longint'(want.compare_value));
                if (o_position !== want.position)
                    report_mismatch("position", longint'(o_position),
                                    longint'(want.position));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d drives still pending",
                     cycle_count, drive_q.size());
            $display("[ball_plate_filter_pd_servo] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: per drive a random wait while rx_idle is set, plus the long
    // hold-off that a test can request through hold_cycles.
    // ------------------------------------------------------------------
    initial begin : receiver
        int gap;
        gap = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else if (gap > 0) begin
                i_stall <= 1'b1;
                gap--;
            end else begin
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            if (o_valid && !i_stall)
                gap = rx_idle ? $urandom_range(0, 10) : 0;
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------
    // Offer one sample after a random gap; returns once it is accepted.
    // Valid stays high afterwards so a zero gap gives back-to-back items.
    task automatic send_sample(input logic ax, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_axis   <= ax;
        i_sample <= smp;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid and wait for every pending drive, then let the pipe settle
    task automatic await_all_drives();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Only called with the block idle
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [CFG_DATA_W-1:0] tx, input logic [CFG_DATA_W-1:0] ty,
                                  input logic [CFG_DATA_W-1:0] px, input logic [CFG_DATA_W-1:0] dx,
                                  input logic [CFG_DATA_W-1:0] py, input logic [CFG_DATA_W-1:0] dy,
                                  input logic [CFG_DATA_W-1:0] lx, input logic [CFG_DATA_W-1:0] ly);
        write_reg(REG_TARGET_X,   tx);
        write_reg(REG_TARGET_Y,   ty);
        write_reg(REG_GAIN_P_X,   px);
        write_reg(REG_GAIN_D_X,   dx);
        write_reg(REG_GAIN_P_Y,   py);
        write_reg(REG_GAIN_D_Y,   dy);
        write_reg(REG_LEVEL_US_X, lx);
        write_reg(REG_LEVEL_US_Y, ly);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset config, sample extremes on both axes, zero history at start
    task automatic test_reset_defaults();
        send_sample(1'b0, 10'd0);
        send_sample(1'b1, 10'd0);
        send_sample(1'b0, 10'd1023);
        send_sample(1'b1, 10'd1023);
        send_sample(1'b0, 10'd1023);
        send_sample(1'b1, 10'd1023);
        send_sample(1'b0, 10'd0);
        send_sample(1'b1, 10'd0);
        await_all_drives();
    endtask

    // Every register at an extreme; too-wide data gets masked, and the
    // levels go outside 1000..2000 (0 and 2047)
    task automatic test_register_writes();
        write_all_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                       16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_sample(1'b0, 10'd0);
        send_sample(1'b1, 10'd1023);
        send_sample(1'b0, 10'd512);
        send_sample(1'b1, 10'd0);
        send_sample(1'b0, 10'd1023);
        send_sample(1'b1, 10'd511);
        await_all_drives();
    endtask

    // Max gains slam the drive into both rails; a run of full-scale
    // samples pushes the filtered position toward its ceiling
    task automatic test_saturation();
        write_all_regs(16'd8000, 16'd8000, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'hFFFF, 16'd1000, 16'd2000);
        for (int k = 0; k < 6; k++)
            send_sample(k[0], 10'd1023);
        for (int k = 0; k < 4; k++)
            send_sample(k[0], 10'd0);
        await_all_drives();
    endtask

    // Receiver holds off long enough for the pipe to fill and stall input
    task automatic test_back_pressure();
        write_all_regs(16'd6256, 16'd6296, 16'd1434, 16'd28672,
                       16'd1638, 16'd34816, 16'd1557, 16'd1525);
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        hold_cycles = 80;
        for (int k = 0; k < 40; k++)
            send_sample(1'($urandom_range(0, 1)), 10'($urandom_range(300, 500)));
        await_all_drives();
    endtask

    // Sender stops mid-stream until the block has returned every drive
    task automatic test_drain_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int k = 0; k < 20; k++)
            send_sample(k[0], 10'($urandom_range(0, 1023)));
        await_all_drives();
        for (int k = 0; k < 20; k++)
            send_sample(k[0], 10'($urandom_range(0, 1023)));
        await_all_drives();
    endtask

    // Random phases, each with its own config and idling mix. Most items
    // are ball-like trajectories around the setpoint with alternating
    // axes; the rest is uniform noise with the odd full-scale sample.
    task automatic test_random_stream();
        int n, len, amp, drift, ctr, s, ax0;
        logic ax;
        for (int p = 0; p < 6; p++) begin
            await_all_drives();
            case (p)
                0: write_all_regs(16'd6256, 16'd6296, 16'd1434, 16'd28672,
                                  16'd1638, 16'd34816, 16'd1557, 16'd1525);
                1: write_all_regs(16'($urandom_range(4000, 12000)),
                                  16'($urandom_range(4000, 12000)),
                                  16'($urandom_range(0, 4095)), 16'($urandom_range(0, 40000)),
                                  16'($urandom_range(0, 4095)), 16'($urandom_range(0, 40000)),
                                  16'($urandom_range(1000, 2000)),
                                  16'($urandom_range(1000, 2000)));
                2: write_all_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                3: write_all_regs(16'($urandom_range(0, 16383)), 16'($urandom_range(0, 16383)),
                                  16'($urandom_range(0, 8191)), 16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 8191)), 16'($urandom_range(0, 65535)),
                                  16'($urandom_range(1000, 2000)),
                                  16'($urandom_range(1000, 2000)));
                4: write_all_regs(16'($urandom_range(0, 16383)), 16'($urandom_range(0, 16383)),
                                  16'd0, 16'd0, 16'd0, 16'd0,
                                  16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)));
                default: write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            endcase
            // phase 1 runs without any idling on either side
            tx_idle = (p == 1) ? 1'b0 : ((p == 3) ? 1'b0 : 1'b1);
            rx_idle = (p == 1) ? 1'b0 : ((p == 2) ? 1'b0 : 1'b1);
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7) begin
                    len   = $urandom_range(8, 40);
                    amp   = $urandom_range(0, 60);
                    drift = int'($urandom_range(0, 200)) - 100;
                    ax0   = $urandom_range(0, 1);
                    for (int k = 0; k < len; k++) begin
                        ax    = ax0[0] ^ k[0];
                        ctr   = ax ? (int'(cfg_m.target_y) >> 4) : (int'(cfg_m.target_x) >> 4);
                        drift = drift + int'($urandom_range(0, 10)) - 5;
                        s     = ctr + drift + int'($urandom_range(0, 2 * amp)) - amp;
                        if (s < 0)
                            s = 0;
                        if (s > 1023)
                            s = 1023;
                        send_sample(ax, s[SAMPLE_W-1:0]);
                    end
                    n += len;
                end else begin
                    len = $urandom_range(4, 20);
                    for (int k = 0; k < len; k++) begin
                        case ($urandom_range(0, 7))
                            0:       s = 0;
                            1:       s = 1023;
                            default: s = $urandom_range(0, 1023);
                        endcase
                        send_sample(1'($urandom_range(0, 1)), s[SAMPLE_W-1:0]);
                    end
                    n += len;
                end
            end
        end
        await_all_drives();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // every input known from time zero
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_axis      = 1'b0;
        i_sample    = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_TARGET_X;
        i_cfg_data  = '0;
        reset_model();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_writes();
        test_saturation();
        test_back_pressure();
        test_drain_pause();
        test_random_stream();

        // nothing pending any more; give the pipe time to show strays
        repeat (4 * SETTLE) @(posedge i_clk);
        if (drive_q.size() != 0)
            report_mismatch("drives never returned", 0, drive_q.size());

        $display("run covered %0d samples, %0d drives, %0d register writes in %0d cycles",
                 items_sent, drives_seen, cfg_writes, cycle_count);
        $display("%s%s", "reset defaults, register extremes, rail saturation, ",
                 "back pressure, drain pause, six random phases");
        if (err_count == 0) begin
            $display("[ball_plate_filter_pd_servo] OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("[ball_plate_filter_pd_servo] ERROR");
        end
        $finish;
    end

endmodule
